// ===== rtl/lcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpd_pkg
// Shared types, codes and the CRC-8 step for the length/CRC-8 packet deframer.
// ----------------------------------------------------------------------------
package lcpd_pkg;

	localparam int CFG_IDX_W = 8;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT   = 8'd3;

	// reset values of the registers
	localparam logic [7:0] START_BYTE_RST = 8'd2;
	localparam logic [7:0] END_BYTE_RST   = 8'd3;
	localparam logic [7:0] CRC_POLY_RST   = 8'd7;
	localparam logic [7:0] CRC_INIT_RST   = 8'd0;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_END = 2'd2;
	localparam logic [1:0] ST_BAD_CRC = 2'd3;

	// shortest length byte that is accepted
	localparam logic [7:0] LEN_MIN = 8'd2;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] crc_poly;
		logic [7:0] crc_init;
	} cfg_t;

	// one byte through an MSB-first CRC-8, implicit x^8 term
	function automatic logic [7:0] crc8_step(input logic [7:0] crc,
			input logic [7:0] data, input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/length_crc8_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// length_crc8_packet_deframer_top
// Deframes start/length/payload/CRC-8/end packets from a byte stream.
// ----------------------------------------------------------------------------
// Status results: each passes through the command queue and then the output register.
// Payload flush: each byte is a registered RAM read (B_RD) and then an output load
// (B_WAIT); the next byte is read only after the previous one is loaded.
// Throughput: one received byte per cycle; data bytes of the next packet wait
// while a flush is queued or running, and every byte waits while the queue is full.
// Reset: arst_n clears parser, queue, sequencer and registers (store not).
// ----------------------------------------------------------------------------
module length_crc8_packet_deframer_top #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// received byte stream
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	// results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [7:0]                     payload_byte,
	output logic                           is_command,
	output logic                           last,
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	import lcpd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = AW + 2;   // queue entry: status code and byte count

	cfg_t          cfg_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic          cmd_push;
	logic          cmd_pop;
	logic [CW-1:0] cmd_wdata;
	logic [CW-1:0] cmd_rdata;
	logic          cmd_full;
	logic          cmd_empty;
	logic          flush_done;

	// registers are always writable; writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
			cfg_q.crc_poly   <= CRC_POLY_RST;
			cfg_q.crc_init   <= CRC_INIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_BYTE: cfg_q.start_byte <= cfg_data;
				REG_END_BYTE:   cfg_q.end_byte   <= cfg_data;
				REG_CRC_POLY:   cfg_q.crc_poly   <= cfg_data;
				REG_CRC_INIT:   cfg_q.crc_init   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: parses each item, writes the store, queues one command per outcome
	lcpd_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_wdata),
		.cmd_full   (cmd_full),
		.flush_done (flush_done)
	);

	// payload store: command, arguments and received CRC of the current packet
	lcpd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// queue decouples parsing from result delivery
	lcpd_fifo #(
		.WIDTH(CW)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_wdata),
		.pop       (cmd_pop),
		.pop_data  (cmd_rdata),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	// back: turns each command into one status item or a run of payload items
	lcpd_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_data     (cmd_rdata),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.flush_done   (flush_done),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.payload_byte (payload_byte),
		.is_command   (is_command),
		.last         (last)
	);

endmodule

// ===== rtl/lcpd_ram.sv =====
// ----------------------------------------------------------------------------
// lcpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lcpd_fifo.sv =====
// ----------------------------------------------------------------------------
// lcpd_fifo
// Two-entry command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module lcpd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/lcpd_front.sv =====
// ----------------------------------------------------------------------------
// lcpd_front
// Byte parser: hunts, checks length, stores bytes, runs the CRC and queues
// one command per packet outcome.
// ----------------------------------------------------------------------------
module lcpd_front #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lcpd_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            ram_we,
	output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic                            cmd_push,
	output logic [$clog2(BUFFER_BYTES)+1:0] cmd_data,
	input  logic                            cmd_full,
	input  logic                            flush_done
);

	import lcpd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [7:0] LEN_LIMIT = 8'(BUFFER_BYTES);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_END  = 2'd3;

	logic [1:0]    phase_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] len_q;
	logic [7:0]    crc_q;
	logic [7:0]    crc_rx_q;
	logic          busy_q;     // flush queued or running: store is read out

	logic          accept;
	logic [AW:0]   count_inc;
	logic          len_bad;
	logic [1:0]    cmd_status;
	logic [AW-1:0] cmd_count;

	assign in_stall  = cmd_full || ((phase_q == PH_DATA) && busy_q);
	assign accept    = in_valid && !in_stall;
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign len_bad   = !(rx_byte inside {[LEN_MIN:LEN_LIMIT - 8'd1]});

	assign ram_we    = accept && (phase_q == PH_DATA);
	assign ram_waddr = count_q;
	assign ram_wdata = rx_byte;

	always_comb begin
		cmd_push   = 1'b0;
		cmd_status = ST_OK;
		cmd_count  = len_q - 1'b1;
		case (phase_q)
			PH_LEN: begin
				if (accept && len_bad) begin
					cmd_push   = 1'b1;
					cmd_status = ST_BAD_LEN;
				end
			end
			PH_END: begin
				cmd_push = accept;
				if (rx_byte != cfg.end_byte) begin
					cmd_status = ST_BAD_END;
				end else if (crc_rx_q != crc_q) begin
					cmd_status = ST_BAD_CRC;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_data = {cmd_status, cmd_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			count_q  <= '0;
			len_q    <= '0;
			crc_q    <= '0;
			crc_rx_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			if (cmd_push && (cmd_status == ST_OK)) begin
				busy_q <= 1'b1;
			end else if (flush_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == cfg.start_byte) begin
							count_q <= '0;
							phase_q <= PH_LEN;
						end
					end
					PH_LEN: begin
						count_q <= '0;
						if (len_bad) begin
							len_q   <= '0;
							phase_q <= PH_HUNT;
						end else begin
							len_q   <= rx_byte[AW-1:0];
							crc_q   <= cfg.crc_init;
							phase_q <= PH_DATA;
						end
					end
					PH_DATA: begin
						if (count_inc < {1'b0, len_q}) begin
							crc_q <= crc8_step(crc_q, rx_byte, cfg.crc_poly);
						end else begin
							crc_rx_q <= rx_byte;
							phase_q  <= PH_END;
						end
						count_q <= count_inc[AW-1:0];
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/lcpd_back.sv =====
// ----------------------------------------------------------------------------
// lcpd_back
// Result sequencer: pops commands, reads stored payload out, drives the
// output register.
// ----------------------------------------------------------------------------
module lcpd_back #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(BUFFER_BYTES)+1:0] cmd_data,
	input  logic                            cmd_empty,
	output logic                            cmd_pop,
	output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr,
	input  logic [7:0]                      ram_rdata,
	output logic                            flush_done,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [7:0]                      payload_byte,
	output logic                            is_command,
	output logic                            last
);

	import lcpd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RD   = 2'd1;
	localparam logic [1:0] B_WAIT = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] cnt_q;
	logic          ovalid_q;
	logic [1:0]    status_q;
	logic [7:0]    pb_q;
	logic          cmd_q;
	logic          last_q;

	logic          can_load;
	logic [1:0]    head_status;
	logic [AW-1:0] head_count;
	logic          at_last;

	assign can_load    = !ovalid_q || !out_stall;
	assign head_status = cmd_data[AW+1:AW];
	assign head_count  = cmd_data[AW-1:0];
	assign at_last     = (({1'b0, idx_q} + 1'b1) == {1'b0, cnt_q});
	assign ram_raddr   = idx_q;

	assign cmd_pop    = (state_q == B_IDLE) && !cmd_empty
			&& ((head_status == ST_OK) || can_load);
	assign flush_done = (state_q == B_WAIT) && can_load && at_last;

	assign out_valid    = ovalid_q;
	assign status       = status_q;
	assign payload_byte = pb_q;
	assign is_command   = cmd_q;
	assign last         = last_q;

	always_ff @(posedge clk) begin
		if (cmd_pop && (head_status != ST_OK)) begin
			status_q <= head_status;
			pb_q     <= 8'd0;
			cmd_q    <= 1'b0;
			last_q   <= 1'b1;
		end else if ((state_q == B_WAIT) && can_load) begin
			status_q <= ST_OK;
			pb_q     <= ram_rdata;
			cmd_q    <= (idx_q == '0);
			last_q   <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if ((cmd_pop && (head_status != ST_OK))
					|| ((state_q == B_WAIT) && can_load)) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (cmd_pop && (head_status == ST_OK)) begin
						idx_q   <= '0;
						cnt_q   <= head_count;
						state_q <= B_RD;
					end
				end
				B_RD: begin
					state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (can_load) begin
						if (at_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_RD;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/tb_length_crc8_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_length_crc8_packet_deframer_top
// Self-checking bench for the length/CRC-8 packet deframer. Byte items are
// pushed in with random gaps and the results are pulled out with random
// stalls. A behavioural model of the parser runs alongside. Every result is
// compared field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_length_crc8_packet_deframer_top;
	import lcpd_pkg::*;

	localparam int BUFFER_BYTES = 64;
	localparam int IDLE_PCT     = 18;    // chance per cycle of a gap or a stall
	localparam int QUIET_CYCLES = 16;    // well past the start of a flush
	localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all

	typedef enum logic [1:0] {P_HUNT, P_GET_LEN, P_GET_DATA, P_GET_END} parse_ph_t;
	typedef enum logic [1:0] {FR_GOOD, FR_BAD_END, FR_BAD_CRC} frame_fault_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
		logic       cmd;
		logic       last;
	} deframed_t;

	// DUT ports; the driven inputs are known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte   = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [7:0]           payload_byte;
	logic                 is_command;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = 8'h00;

	// parser model: registers and state
	logic [7:0] m_start = START_BYTE_RST;
	logic [7:0] m_end   = END_BYTE_RST;
	logic [7:0] m_poly  = CRC_POLY_RST;
	logic [7:0] m_init  = CRC_INIT_RST;
	parse_ph_t  m_ph    = P_HUNT;
	logic [6:0] m_cnt   = '0;
	logic [5:0] m_len   = '0;
	logic [7:0] m_crc   = 8'h00;
	logic [7:0] m_store [BUFFER_BYTES];

	deframed_t  deframed_q [$];   // results predicted and not yet seen
	logic [7:0] frame_body [$];   // command and arguments of the frame being built

	bit no_idle      = 1'b0;
	int quiet_cycles = 0;
	int n_fail       = 0;
	int n_bytes_in   = 0;
	int n_ignored    = 0;
	int n_results    = 0;
	int n_good       = 0;
	int n_bad_len    = 0;
	int n_bad_end    = 0;
	int n_bad_crc    = 0;
	int n_settings   = 1;

	length_crc8_packet_deframer_top #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.payload_byte(payload_byte),
		.is_command  (is_command),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------

	// MSB-first CRC-8 step with the polynomial currently in the register
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ m_poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// Advance the model by one accepted byte and queue what it must produce.
	task automatic deframe_byte(input logic [7:0] b);
		int n;
		case (m_ph)
			P_HUNT: begin
				// anything but the start byte is dropped silently
				if (b == m_start) begin
					m_cnt = '0;
					m_ph  = P_GET_LEN;
				end else begin
					n_ignored++;
				end
			end
			P_GET_LEN: begin
				if (b < LEN_MIN || b >= BUFFER_BYTES) begin
					m_cnt = '0;
					m_len = '0;
					m_ph  = P_HUNT;
					deframed_q.push_back('{status: ST_BAD_LEN, data: 8'h00,
						cmd: 1'b0, last: 1'b1});
					n_bad_len++;
				end else begin
					m_len = b[5:0];
					m_cnt = '0;
					m_crc = m_init;
					m_ph  = P_GET_DATA;
				end
			end
			P_GET_DATA: begin
				// start/end values in here are plain data, no resync
				m_store[m_cnt[5:0]] = b;
				if (m_cnt + 1 < m_len) begin
					m_crc = crc8_next(m_crc, b);
				end
				m_cnt = m_cnt + 7'd1;
				if (m_cnt >= m_len) begin
					m_ph = P_GET_END;
				end
			end
			default: begin
				m_ph = P_HUNT;
				if (b != m_end) begin
					// end byte takes precedence over the CRC
					deframed_q.push_back('{status: ST_BAD_END, data: 8'h00,
						cmd: 1'b0, last: 1'b1});
					n_bad_end++;
				end else if (m_store[m_len - 1] != m_crc) begin
					deframed_q.push_back('{status: ST_BAD_CRC, data: 8'h00,
						cmd: 1'b0, last: 1'b1});
					n_bad_crc++;
				end else begin
					n = m_len - 1;
					for (int i = 0; i < n; i++) begin
						deframed_q.push_back('{status: ST_OK, data: m_store[i],
							cmd: (i == 0), last: (i == n - 1)});
					end
					n_good++;
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stalls, checks at the falling edge
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic check_result();
		deframed_t exp_r;
		if (deframed_q.size() == 0) begin
			$error("unexpected result: status=%0d payload_byte=0x%02h is_command=%0b last=%0b",
				status, payload_byte, is_command, last);
			n_fail++;
		end else begin
			exp_r = deframed_q.pop_front();
			if (status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, status);
				n_fail++;
			end
			if (payload_byte !== exp_r.data) begin
				$error("payload_byte: expected 0x%02h, got 0x%02h", exp_r.data, payload_byte);
				n_fail++;
			end
			if (is_command !== exp_r.cmd) begin
				$error("is_command: expected %0b, got %0b", exp_r.cmd, is_command);
				n_fail++;
			end
			if (last !== exp_r.last) begin
				$error("last: expected %0b, got %0b", exp_r.last, last);
				n_fail++;
			end
		end
		n_results++;
	endtask

	// Everything driven changes at the rising edge, so the falling edge sees
	// settled handshakes: whatever is valid and unstalled here goes through
	// at the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (out_valid && !out_stall) begin
				check_result();
			end
		end
	end

	// watchdog: nothing moving on any channel for too long
	initial begin
		wait (arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(negedge clk);
		end
		$error("watchdog: no handshake for %0d cycles, %0d results outstanding",
			STALL_LIMIT, deframed_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte and register drivers
	// ------------------------------------------------------------------------

	// Called at a rising edge; returns at the edge the item is taken, with
	// in_valid still high so a back-to-back item needs no second assignment.
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		deframe_byte(b);
		n_bytes_in++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		case (idx)
			REG_START_BYTE: m_start = val;
			REG_END_BYTE:   m_end   = val;
			REG_CRC_POLY:   m_poly  = val;
			REG_CRC_INIT:   m_init  = val;
			default: ;  // unmapped index, dropped
		endcase
	endtask

	// all four registers plus one write to an unmapped index
	task automatic set_registers(input logic [7:0] sb, input logic [7:0] eb,
			input logic [7:0] poly, input logic [7:0] init, input logic [CFG_IDX_W-1:0] junk);
		write_reg(REG_START_BYTE, sb);
		write_reg(REG_END_BYTE, eb);
		write_reg(REG_CRC_POLY, poly);
		write_reg(REG_CRC_INIT, init);
		write_reg(junk, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// sender holds off until every predicted result has been taken
	task automatic hold_for_results();
		in_valid <= 1'b0;
		while (deframed_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// block fully idle: no results owed and no flush still in flight
	task automatic settle_idle();
		hold_for_results();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// bring the parser back to hunting so a register write lands between frames
	task automatic drain_parser();
		while (m_ph != P_HUNT) begin
			if (m_ph == P_GET_LEN) begin
				send_byte(8'h00);
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Frame builders
	// ------------------------------------------------------------------------

	// start, length, frame_body, CRC, end, with an optional fault
	task automatic send_packet(input frame_fault_t fault);
		logic [7:0] crc;
		crc = m_init;
		foreach (frame_body[i]) begin
			crc = crc8_next(crc, frame_body[i]);
		end
		if (fault == FR_BAD_CRC) begin
			crc = crc ^ 8'($urandom_range(1, 255));
		end
		send_byte(m_start);
		send_byte(8'(frame_body.size() + 1));
		foreach (frame_body[i]) begin
			send_byte(frame_body[i]);
		end
		send_byte(crc);
		send_byte(fault == FR_BAD_END ? m_end ^ 8'($urandom_range(1, 255)) : m_end);
	endtask

	// random body; start and end values are slipped in now and then as data
	task automatic send_frame(input int len, input frame_fault_t fault);
		int r;
		frame_body.delete();
		for (int i = 0; i < len - 1; i++) begin
			r = $urandom_range(15);
			if (r == 0) begin
				frame_body.push_back(m_start);
			end else if (r == 1) begin
				frame_body.push_back(m_end);
			end else begin
				frame_body.push_back(8'($urandom_range(255)));
			end
		end
		send_packet(fault);
	endtask

	task automatic send_bad_length(input logic [7:0] len);
		send_byte(m_start);
		send_byte(len);
	endtask

	// mostly short frames, the odd long one, now and then the longest
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 75) begin
			return $urandom_range(2, 8);
		end else if (r < 95) begin
			return $urandom_range(9, BUFFER_BYTES - 1);
		end
		return BUFFER_BYTES - 1;
	endfunction

	function automatic logic [7:0] pick_bad_len();
		if ($urandom_range(99) < 30) begin
			return 8'($urandom_range(0, 1));
		end
		return 8'($urandom_range(BUFFER_BYTES, 255));
	endfunction

	// Mostly well-formed frames, the rest faulty frames and line noise.
	// Counts only bytes the parser actually acts on.
	task automatic random_frames(input int target);
		int base;
		int r;
		base = n_bytes_in - n_ignored;
		while ((n_bytes_in - n_ignored) - base < target) begin
			r = $urandom_range(99);
			if (r < 68) begin
				send_frame(pick_len(), FR_GOOD);
			end else if (r < 78) begin
				send_frame(pick_len(), FR_BAD_CRC);
			end else if (r < 86) begin
				send_frame(pick_len(), FR_BAD_END);
			end else if (r < 93) begin
				send_bad_length(pick_bad_len());
			end else begin
				// noise; a stray start value here opens a bogus frame
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			end
		end
		drain_parser();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// reset register values: ignored bytes, bad lengths, the three frame outcomes
	task automatic test_directed_defaults();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_bad_length(8'd0);
		send_bad_length(8'd1);
		send_bad_length(8'(BUFFER_BYTES));
		// shortest frame, command equal to the start value
		frame_body.delete();
		frame_body.push_back(m_start);
		send_packet(FR_GOOD);
		frame_body.delete();
		frame_body.push_back(8'hA5);
		send_packet(FR_BAD_END);
		frame_body.delete();
		frame_body.push_back(8'h5A);
		send_packet(FR_BAD_CRC);
		drain_parser();
	endtask

	// two extreme register settings (each field 00 or FF) with min/max lengths
	task automatic test_register_extremes();
		for (int s = 0; s < 2; s++) begin
			settle_idle();
			if (s == 0) begin
				set_registers(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
			end else begin
				set_registers(8'hFF, 8'h00, 8'h00, 8'h00, 8'h04);
			end
			send_frame(2, FR_GOOD);
			send_frame(BUFFER_BYTES - 1, FR_GOOD);
			send_frame(5, FR_BAD_CRC);
			send_frame(4, FR_BAD_END);
			send_bad_length(8'hFF);
			drain_parser();
		end
	endtask

	// no gaps and no stalls: frames queue up behind a long flush
	task automatic test_back_to_back();
		settle_idle();
		set_registers(START_BYTE_RST, END_BYTE_RST, CRC_POLY_RST, CRC_INIT_RST,
			CFG_IDX_W'($urandom_range(4, 255)));
		no_idle = 1'b1;
		send_frame(BUFFER_BYTES - 1, FR_GOOD);
		send_frame(2, FR_GOOD);
		send_frame(3, FR_GOOD);
		send_bad_length(8'd1);
		send_frame(6, FR_BAD_CRC);
		send_frame(2, FR_GOOD);
		send_frame(20, FR_GOOD);
		drain_parser();
		hold_for_results();
		no_idle = 1'b0;
	endtask

	// three random register settings, each with a full drain halfway through
	task automatic test_random_traffic();
		for (int s = 0; s < 3; s++) begin
			settle_idle();
			set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)),
				CFG_IDX_W'($urandom_range(4, 255)));
			random_frames(18);
			hold_for_results();
			random_frames(18);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_back_to_back();
		test_random_traffic();

		settle_idle();
		$display("Run covered %0d bytes in %0d register settings: %0d good frames, %0d bad length,",
			n_bytes_in, n_settings, n_good, n_bad_len);
		$display("%0d bad end, %0d bad CRC; %0d results compared.",
			n_bad_end, n_bad_crc, n_results);
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
